@@ sv/rv32ie_pkg.sv @@
`default_nettype none
package rv32ie_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ECALL   = 2'd1,
    ST_EBREAK  = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_e;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] W_ECALL  = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_SW  = 3'd2;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
  } dmem_req_t;

  typedef struct packed {
    logic [31:0] pc_next;
    logic        flow;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [31:0] addr;
    status_e     status;
  } result_t;

  function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                         logic [31:0] b);
    logic [4:0]  sh;
    logic [31:0] r;
    sh = b[4:0];
    case (f3)
      F3_ADD:  r = alt ? (a - b) : (a + b);
      F3_SLL:  r = a << sh;
      F3_SLT:  r = {31'b0, ($signed(a) < $signed(b))};
      F3_SLTU: r = {31'b0, (a < b)};
      F3_XOR:  r = a ^ b;
      F3_SR:   r = alt ? 32'($signed(a) >>> sh) : (a >> sh);
      F3_OR:   r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/rv32ie_regfile.sv @@
`default_nettype none
module rv32ie_regfile (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        re_i,
  input  wire logic [4:0]  raddr1_i,
  input  wire logic [4:0]  raddr2_i,
  input  wire logic        we_i,
  input  wire logic [4:0]  waddr_i,
  input  wire logic [31:0] wdata_i,
  output logic      [31:0] rdata1_o,
  output logic      [31:0] rdata2_o
);

  logic [31:0] mem [32];
  logic [31:0] valid_q;
  logic [31:0] rd1_q, rd2_q;
  logic        v1_q, v2_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd1_q <= mem[raddr1_i];
      rd2_q <= mem[raddr2_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        v1_q <= valid_q[raddr1_i];
        v2_q <= valid_q[raddr2_i];
      end
    end
  end

  assign rdata1_o = v1_q ? rd1_q : '0;
  assign rdata2_o = v2_q ? rd2_q : '0;

endmodule
`default_nettype wire

@@ sv/rv32ie_dmem.sv @@
`default_nettype none
module rv32ie_dmem import rv32ie_pkg::*; #(
  parameter int unsigned DMEM_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dmem_req_t   req_i,
  output logic      [31:0] rdata_o,
  output logic             busy_o
);

  localparam int unsigned WORDS = DMEM_BYTES / 4;
  localparam int unsigned WI    = $clog2(WORDS);

  logic [WI:0]   clr_q;
  logic [1:0]    off;
  logic [WI-1:0] w0, w1;
  logic [2:0]    nbytes;
  logic [WI-1:0] lane_addr [4];
  logic          lane_use  [4];
  logic [7:0]    lane_wd   [4];
  logic [7:0]    lane_q    [4];
  logic [1:0]    off_q;
  logic [2:0]    nbytes_q;

  assign busy_o = !clr_q[WI];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign off = req_i.addr[1:0];
  assign w0  = req_i.addr[WI+1:2];
  assign w1  = w0 + 1'b1;

  always_comb begin
    case (req_i.size)
      2'd0:    nbytes = 3'd1;
      2'd1:    nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
  end

  // each lane holds byte k of the access, at the start word or the one after
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0] mem [WORDS];
    logic [1:0] k;
    logic [31:0] sh;

    assign k              = 2'(l) - off;
    assign sh             = req_i.wdata >> {k, 3'b000};
    assign lane_addr[l]   = (2'(l) >= off) ? w0 : w1;
    assign lane_use[l]    = ({1'b0, k} < nbytes);
    assign lane_wd[l]     = sh[7:0];

    always_ff @(posedge clk_i) begin
      if (busy_o) begin
        mem[clr_q[WI-1:0]] <= '0;
      end else if (req_i.wr && lane_use[l]) begin
        mem[lane_addr[l]] <= lane_wd[l];
      end
      if (req_i.rd) begin
        lane_q[l] <= mem[lane_addr[l]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      off_q    <= off;
      nbytes_q <= nbytes;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdata_o[8*k +: 8] = (3'(k) < nbytes_q) ? lane_q[2'(off_q + 2'(k))] : 8'h00;
    end
  end

endmodule
`default_nettype wire

@@ sv/rv32i_integer_execute.sv @@
`default_nettype none
// RV32I execute block: each transfer on the input channel is one instruction word,
// executed against the register file, the pc and the byte data memory, and each
// gives one result transfer. Register file and data memory are synchronous RAMs;
// an instruction reads operands on the accept edge and executes in the next cycle,
// so non-load instructions sustain one per cycle unless the output stalls; a load
// goes on to a load stage for the memory read, and no instruction is taken while
// it is in execute. After reset the data memory is cleared, and input is held off.
// DMEM_BYTES must be a power of two. Writing the configuration word loads the pc.
module rv32i_integer_execute import rv32ie_pkg::*; #(
  parameter int unsigned DMEM_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instr_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] pc_next_o,
  output logic             flow_taken_o,
  output logic             rd_write_o,
  output logic      [4:0]  rd_index_o,
  output logic      [31:0] rd_value_o,
  output logic      [31:0] mem_address_o,
  output logic      [1:0]  status_o
);

  logic        accept, adv, busy;
  logic        d_vld_q, l_vld_q, o_vld_q;
  logic [31:0] d_instr_q, pc_q;
  logic [2:0]  l_f3_q;
  result_t     l_res_q, o_res_q, d_res, l_fin_res;
  logic        d_load, d_store, d_fin, d_to_l, l_fin;
  logic        byp_vld_q;
  logic [4:0]  byp_idx_q;
  logic [31:0] byp_val_q;
  logic        rf_we;
  logic [4:0]  rf_widx;
  logic [31:0] rf_wval, rf_rd1, rf_rd2, a, b;
  dmem_req_t   dreq;
  logic [31:0] drdata, ldval;

  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rs1, rs2, rdf;
  logic [31:0] immi, imms, immb, immj, immu, ea, jsum;
  logic        take, ill;

  assign cfg_ready_o = 1'b1;

  assign adv        = !(o_vld_q && out_stall_i);
  assign in_stall_o = busy || (d_vld_q && (d_load || !adv)) || (l_vld_q && !adv);
  assign accept     = in_valid_i && !in_stall_o;
  assign d_fin      = d_vld_q && !d_load && adv;
  assign d_to_l     = d_vld_q && d_load;
  assign l_fin      = l_vld_q && adv;

  rv32ie_regfile u_rf (
    .clk_i,
    .rst_ni,
    .re_i     (accept),
    .raddr1_i (instr_word_i[19:15]),
    .raddr2_i (instr_word_i[24:20]),
    .we_i     (rf_we),
    .waddr_i  (rf_widx),
    .wdata_i  (rf_wval),
    .rdata1_o (rf_rd1),
    .rdata2_o (rf_rd2)
  );

  rv32ie_dmem #(.DMEM_BYTES(DMEM_BYTES)) u_dmem (
    .clk_i,
    .rst_ni,
    .req_i   (dreq),
    .rdata_o (drdata),
    .busy_o  (busy)
  );

  assign op   = d_instr_q[6:0];
  assign rdf  = d_instr_q[11:7];
  assign f3   = d_instr_q[14:12];
  assign rs1  = d_instr_q[19:15];
  assign rs2  = d_instr_q[24:20];
  assign f7   = d_instr_q[31:25];
  assign immi = {{20{d_instr_q[31]}}, d_instr_q[31:20]};
  assign imms = {{20{d_instr_q[31]}}, d_instr_q[31:25], d_instr_q[11:7]};
  assign immb = {{19{d_instr_q[31]}}, d_instr_q[31], d_instr_q[7], d_instr_q[30:25],
                 d_instr_q[11:8], 1'b0};
  assign immj = {{11{d_instr_q[31]}}, d_instr_q[31], d_instr_q[19:12], d_instr_q[20],
                 d_instr_q[30:21], 1'b0};
  assign immu = {d_instr_q[31:12], 12'h000};

  // a write on the accept edge is not yet in the RAM read data
  assign a = (byp_vld_q && byp_idx_q == rs1) ? byp_val_q : rf_rd1;
  assign b = (byp_vld_q && byp_idx_q == rs2) ? byp_val_q : rf_rd2;

  assign ea   = a + ((op == OP_STORE) ? imms : immi);
  assign jsum = a + immi;

  always_comb begin
    d_res         = '0;
    d_res.pc_next = pc_q + 32'd4;
    d_res.status  = ST_OK;
    d_load        = 1'b0;
    d_store       = 1'b0;
    take          = 1'b0;
    ill           = 1'b0;
    case (op)
      OP_LUI: begin
        d_res.wr  = 1'b1;
        d_res.val = immu;
      end
      OP_AUIPC: begin
        d_res.wr  = 1'b1;
        d_res.val = pc_q + immu;
      end
      OP_JAL: begin
        d_res.wr      = 1'b1;
        d_res.val     = pc_q + 32'd4;
        d_res.flow    = 1'b1;
        d_res.pc_next = pc_q + immj;
      end
      OP_JALR: begin
        if (f3 != 3'd0) begin
          ill = 1'b1;
        end else begin
          d_res.wr      = 1'b1;
          d_res.val     = pc_q + 32'd4;
          d_res.flow    = 1'b1;
          d_res.pc_next = {jsum[31:1], 1'b0};
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = !($signed(a) < $signed(b));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: ill = 1'b1;
        endcase
        if (take) begin
          d_res.flow    = 1'b1;
          d_res.pc_next = pc_q + immb;
        end
      end
      OP_LOAD: begin
        if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
          d_load     = 1'b1;
          d_res.wr   = 1'b1;
          d_res.addr = ea;
        end else begin
          ill = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 > 3'd2) begin
          ill = 1'b1;
        end else begin
          d_store    = 1'b1;
          d_res.addr = ea;
        end
      end
      OP_IMM: begin
        if (f3 == F3_SLL) begin
          if (f7 != F7_BASE) ill = 1'b1;
          else d_res.val = alu_op(F3_SLL, 1'b0, a, {27'b0, rs2});
        end else if (f3 == F3_SR) begin
          if (f7 != F7_BASE && f7 != F7_ALT) ill = 1'b1;
          else d_res.val = alu_op(F3_SR, f7 == F7_ALT, a, {27'b0, rs2});
        end else begin
          d_res.val = alu_op(f3, 1'b0, a, immi);
        end
        d_res.wr = !ill;
      end
      OP_REG: begin
        if (f7 != F7_BASE && f7 != F7_ALT) begin
          ill = 1'b1;
        end else if (f7 == F7_ALT && f3 != F3_ADD && f3 != F3_SR) begin
          ill = 1'b1;
        end else begin
          d_res.wr  = 1'b1;
          d_res.val = alu_op(f3, f7 == F7_ALT, a, b);
        end
      end
      OP_FENCE: begin
        ill = (f3 != 3'd0);
      end
      OP_SYSTEM: begin
        if (d_instr_q == W_ECALL) d_res.status = ST_ECALL;
        else if (d_instr_q == W_EBREAK) d_res.status = ST_EBREAK;
        else ill = 1'b1;
      end
      default: ill = 1'b1;
    endcase
    if (ill) begin
      d_res.status  = ST_ILLEGAL;
      d_res.wr      = 1'b0;
      d_res.flow    = 1'b0;
      d_res.pc_next = pc_q + 32'd4;
    end
    // drop writes to x0
    if (d_res.wr && rdf != 5'd0) begin
      d_res.rd = rdf;
    end else begin
      d_res.wr  = 1'b0;
      d_res.rd  = 5'd0;
      d_res.val = '0;
    end
  end

  assign dreq.rd    = d_to_l;
  assign dreq.wr    = d_fin && d_store;
  assign dreq.size  = f3[1:0];
  assign dreq.addr  = ea;
  assign dreq.wdata = b;

  always_comb begin
    case (l_f3_q)
      F3_LB:   ldval = {{24{drdata[7]}}, drdata[7:0]};
      F3_LH:   ldval = {{16{drdata[15]}}, drdata[15:0]};
      default: ldval = drdata;
    endcase
    l_fin_res     = l_res_q;
    l_fin_res.val = l_res_q.wr ? ldval : '0;
  end

  always_comb begin
    if (l_fin) begin
      rf_we   = l_fin_res.wr;
      rf_widx = l_fin_res.rd;
      rf_wval = l_fin_res.val;
    end else begin
      rf_we   = d_fin && d_res.wr;
      rf_widx = d_res.rd;
      rf_wval = d_res.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q   <= 1'b0;
      l_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
      pc_q      <= '0;
      byp_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        d_vld_q   <= 1'b1;
        byp_vld_q <= rf_we;
      end else if (d_fin || d_to_l) begin
        d_vld_q <= 1'b0;
      end
      if (d_to_l) begin
        l_vld_q <= 1'b1;
      end else if (l_fin) begin
        l_vld_q <= 1'b0;
      end
      if (d_fin || l_fin) begin
        o_vld_q <= 1'b1;
      end else if (adv) begin
        o_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pc_q <= cfg_data_i;
      end else if (d_fin || d_to_l) begin
        pc_q <= d_res.pc_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      d_instr_q <= instr_word_i;
      byp_idx_q <= rf_widx;
      byp_val_q <= rf_wval;
    end
    if (d_to_l) begin
      l_res_q <= d_res;
      l_f3_q  <= f3;
    end
    if (l_fin) begin
      o_res_q <= l_fin_res;
    end else if (d_fin) begin
      o_res_q <= d_res;
    end
  end

  assign out_valid_o   = o_vld_q;
  assign pc_next_o     = o_res_q.pc_next;
  assign flow_taken_o  = o_res_q.flow;
  assign rd_write_o    = o_res_q.wr;
  assign rd_index_o    = o_res_q.rd;
  assign rd_value_o    = o_res_q.val;
  assign mem_address_o = o_res_q.addr;
  assign status_o      = o_res_q.status;

  a_single_inflight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(d_vld_q && l_vld_q))
    else $error("execute and load stages both occupied");

  a_load_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_vld_q && d_load) |=> l_vld_q)
    else $error("load did not move to load stage");

  a_no_x0_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rf_we && rf_widx == 5'd0))
    else $error("register file write to x0");

endmodule
`default_nettype wire

@@ tb/rv32i_integer_execute_tb.sv @@
module rv32i_integer_execute_tb;
  import rv32ie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] pc_next;
    logic        flow;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [31:0] addr;
    logic [1:0]  status;
  } exec_res_t;

  class exec_scoreboard;
    logic [31:0] regs[32];
    logic [31:0] pc;
    logic [7:0]  mem[MEM_BYTES];
    exec_res_t   pending[$];
    int          mismatches;

    function void clear_state();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
    endfunction

    function logic [31:0] mem_rd(logic [31:0] a, int n);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v[8*i +: 8] = mem[(a + i) % MEM_BYTES];
      return v;
    endfunction

    function logic [31:0] alu_calc(logic [2:0] f3, logic alt, logic [31:0] a, logic [31:0] b);
      case (f3)
        F3_ADD:  return alt ? a - b : a + b;
        F3_SLL:  return a << b[4:0];
        F3_SLT:  return {31'b0, $signed(a) < $signed(b)};
        F3_SLTU: return {31'b0, a < b};
        F3_XOR:  return a ^ b;
        F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        F3_OR:   return a | b;
        default: return a & b;
      endcase
    endfunction

    function void note_instr(logic [31:0] w);
      logic [6:0] op, f7;
      logic [4:0] rd, rs1, rs2;
      logic [2:0] f3;
      logic [31:0] a, b, immi, imms, off, ea, m;
      exec_res_t r;
      logic take;
      op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
      f7 = w[31:25];
      a = regs[rs1]; b = regs[rs2];
      immi = {{20{w[31]}}, w[31:20]};
      imms = {{20{w[31]}}, w[31:25], w[11:7]};
      r = '0;
      r.pc_next = pc + 4;
      case (op)
        OP_LUI: begin r.wr = 1; r.val = {w[31:12], 12'b0}; end
        OP_AUIPC: begin r.wr = 1; r.val = pc + {w[31:12], 12'b0}; end
        OP_JAL: begin
          off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
          r.wr = 1; r.val = pc + 4; r.flow = 1; r.pc_next = pc + off;
        end
        OP_JALR: begin
          if (f3 != 0) r.status = ST_ILLEGAL;
          else begin
            r.wr = 1; r.val = pc + 4; r.flow = 1; r.pc_next = (a + immi) & ~32'd1;
          end
        end
        OP_BRANCH: begin
          off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          take = 0;
          case (f3)
            F3_BEQ:  take = a == b;
            F3_BNE:  take = a != b;
            F3_BLT:  take = $signed(a) < $signed(b);
            F3_BGE:  take = $signed(a) >= $signed(b);
            F3_BLTU: take = a < b;
            F3_BGEU: take = a >= b;
            default: r.status = ST_ILLEGAL;
          endcase
          if (take) begin r.flow = 1; r.pc_next = pc + off; end
        end
        OP_LOAD: begin
          ea = a + immi;
          case (f3)
            F3_LB: begin
              m = mem_rd(ea, 1);
              r.val = {{24{m[7]}}, m[7:0]};
            end
            F3_LH: begin
              m = mem_rd(ea, 2);
              r.val = {{16{m[15]}}, m[15:0]};
            end
            F3_LW:  r.val = mem_rd(ea, 4);
            F3_LBU: r.val = mem_rd(ea, 1);
            F3_LHU: r.val = mem_rd(ea, 2);
            default: r.status = ST_ILLEGAL;
          endcase
          if (r.status == ST_OK) begin r.wr = 1; r.addr = ea; end
        end
        OP_STORE: begin
          ea = a + imms;
          if (f3 > 2) r.status = ST_ILLEGAL;
          else begin
            for (int i = 0; i < (1 << f3); i++) mem[(ea + i) % MEM_BYTES] = b[8*i +: 8];
            r.addr = ea;
          end
        end
        OP_IMM: begin
          if (f3 == F3_SLL) begin
            if (f7 != F7_BASE) r.status = ST_ILLEGAL;
            else r.val = alu_calc(F3_SLL, 0, a, {27'b0, rs2});
          end else if (f3 == F3_SR) begin
            if (f7 != F7_BASE && f7 != F7_ALT) r.status = ST_ILLEGAL;
            else r.val = alu_calc(F3_SR, f7 == F7_ALT, a, {27'b0, rs2});
          end else r.val = alu_calc(f3, 0, a, immi);
          r.wr = r.status == ST_OK;
        end
        OP_REG: begin
          if ((f7 != F7_BASE && f7 != F7_ALT) ||
              (f7 == F7_ALT && f3 != F3_ADD && f3 != F3_SR)) r.status = ST_ILLEGAL;
          else begin r.wr = 1; r.val = alu_calc(f3, f7 == F7_ALT, a, b); end
        end
        OP_FENCE: if (f3 != 0) r.status = ST_ILLEGAL;
        OP_SYSTEM: begin
          if (w == W_ECALL) r.status = ST_ECALL;
          else if (w == W_EBREAK) r.status = ST_EBREAK;
          else r.status = ST_ILLEGAL;
        end
        default: r.status = ST_ILLEGAL;
      endcase
      if (r.status == ST_ILLEGAL) begin
        r.wr = 0; r.flow = 0; r.addr = 0; r.pc_next = pc + 4;
      end
      if (r.wr && rd != 0) begin
        r.rd = rd; regs[rd] = r.val;
      end else begin
        r.wr = 0; r.rd = 0; r.val = 0;
      end
      pc = r.pc_next;
      pending.push_back(r);
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: exp pc=%h fl=%b wr=%b rd=%0d v=%h a=%h st=%0d",
                   want.pc_next, want.flow, want.wr, want.rd, want.val, want.addr,
                   want.status);
          $display("                 got pc=%h fl=%b wr=%b rd=%0d v=%h a=%h st=%0d",
                   got.pc_next, got.flow, got.wr, got.rd, got.val, got.addr, got.status);
        end
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0, in_valid_i = 0, out_stall_i = 0;
  logic [31:0] cfg_data_i = '0, instr_word_i = '0;
  logic cfg_ready_o, in_stall_o, out_valid_o;
  logic [31:0] pc_next_o, rd_value_o, mem_address_o;
  logic flow_taken_o, rd_write_o;
  logic [4:0] rd_index_o;
  logic [1:0] status_o;

  exec_scoreboard sb = new();
  bit quiet_tail;
  int idle_cycles;

  always #5 clk_i = ~clk_i;

  rv32i_integer_execute DUT (.*);

  // check results and keep the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result({pc_next_o, flow_taken_o, rd_write_o, rd_index_o, rd_value_o,
                         mem_address_o, status_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  task automatic send_instr(logic [31:0] w);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    instr_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_instr(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_start(logic [31:0] v);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.pc = v;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [4:0] rs2, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [4:0] pick_reg();
    return $urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  // mostly well-formed instructions with random content, small register set
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    rd = pick_reg(); rs1 = pick_reg(); rs2 = pick_reg(); f3 = 3'($urandom);
    w = $urandom;
    case ($urandom_range(0, 15))
      0: w = {w[31:12], rd, OP_LUI};
      1: w = {w[31:12], rd, OP_AUIPC};
      2: w = {w[31:12], rd, OP_JAL};
      3: w = enc_i(OP_JALR, F3_ADD, rd, rs1, 12'($urandom));
      4, 5: w = {w[31:25], rs2, rs1, f3, w[11:7], OP_BRANCH};
      6, 7: w = enc_i(OP_LOAD, $urandom_range(0, 9) == 0 ? f3 : 3'($urandom_range(0, 5)),
                      rd, rs1, 12'($urandom));
      8, 9: w = {w[31:25], rs2, rs1, $urandom_range(0, 9) == 0 ? f3 : 3'($urandom_range(0, 2)),
                 w[11:7], OP_STORE};
      10: w = enc_i(OP_IMM, f3, rd, rs1, 12'($urandom));
      11: w = enc_r($urandom_range(0, 1) ? F7_ALT : F7_BASE, f3, rd, rs1, rs2, OP_IMM);
      12, 13: w = enc_r($urandom_range(0, 9) == 0 ? 7'($urandom) :
                        ($urandom_range(0, 1) ? F7_ALT : F7_BASE), f3, rd, rs1, rs2, OP_REG);
      14: case ($urandom_range(0, 3))
            0: w = W_ECALL;
            1: w = W_EBREAK;
            2: w = {w[31:15], f3, w[11:7], OP_FENCE};
            default: w = {w[31:7], OP_SYSTEM};
          endcase
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    sb.clear_state();
    repeat (12) @(negedge clk_i);
    rst_ni = 1;

    // directed: extremes, every opcode, special cases
    send_instr({20'hFFFFF, 5'd1, OP_LUI});
    send_instr({20'h80000, 5'd0, OP_LUI});
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd2, 5'd0, 12'h7FF));
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd3, 5'd0, 12'h800));
    send_instr(enc_r(F7_ALT, F3_SR, 5'd4, 5'd1, 5'd31, OP_IMM));
    send_instr(enc_r(F7_ALT, F3_SLL, 5'd4, 5'd1, 5'd3, OP_IMM));
    send_instr(enc_r(F7_ALT, F3_ADD, 5'd5, 5'd2, 5'd3, OP_REG));
    send_instr(enc_r(F7_ALT, F3_XOR, 5'd5, 5'd2, 5'd3, OP_REG));
    send_instr({7'h7F, 5'd1, 5'd3, F3_SLL, 5'h1F, OP_STORE});
    send_instr({7'h00, 5'd1, 5'd2, F3_SW, 5'h00, OP_STORE});
    send_instr(enc_i(OP_LOAD, F3_LW, 5'd6, 5'd2, 12'hFFF));
    send_instr(enc_i(OP_LOAD, F3_LB, 5'd7, 5'd3, 12'hFFF));
    send_instr(enc_i(OP_LOAD, F3_LHU, 5'd8, 5'd0, 12'h000));
    send_instr(enc_i(OP_LOAD, 3'd7, 5'd8, 5'd0, 12'h000));
    send_instr({7'h7F, 5'd2, 5'd3, F3_BLT, 5'h1F, OP_BRANCH});
    send_instr({7'h00, 5'd2, 5'd3, F3_BLTU, 5'h03, OP_BRANCH});
    send_instr({7'h00, 5'd2, 5'd3, 3'd2, 5'h04, OP_BRANCH});
    send_instr({20'hFFFFF, 5'd9, OP_JAL});
    send_instr(enc_i(OP_JALR, F3_ADD, 5'd10, 5'd1, 12'h801));
    send_instr({20'h12345, 5'd11, OP_AUIPC});
    send_instr(W_ECALL);
    send_instr(W_EBREAK);
    send_instr(32'h0000_100F);
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    drain();

    // random phases over several start addresses, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_start(32'hFFFF_FFFC);
        1: set_start(32'h0000_0000);
        2: set_start(32'hFFFF_FFFF);
        default: set_start($urandom);
      endcase
      if (ph == 5) quiet_tail = 1;
      for (int k = 0; k < 300; k++) send_instr(random_instr());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/rv32ie_pkg.sv
sv/rv32ie_regfile.sv
sv/rv32ie_dmem.sv
sv/rv32i_integer_execute.sv
tb/rv32i_integer_execute_tb.sv
